[design/stt_pkg.sv]
package stt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_IDENT  = 4'd1,
    MODE_NUMBER = 4'd2,
    MODE_OPER   = 4'd3,
    MODE_DOLLAR = 4'd4,
    MODE_LINE   = 4'd5,
    MODE_BLOCK  = 4'd6,
    MODE_TILDE  = 4'd7,
    MODE_FATAL  = 4'd8
  } mode_t;

  localparam logic [5:0] KIND_IDENT   = 6'd11;
  localparam logic [5:0] KIND_INTEGER = 6'd12;
  localparam logic [5:0] KIND_EOF     = 6'd46;
  localparam logic [5:0] KIND_ERROR   = 6'd47;
  localparam logic [5:0] KIND_NONE    = 6'd63;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_AMP     = 3'd2;
  localparam logic [2:0] ERR_BAR     = 3'd3;
  localparam logic [2:0] ERR_COMMENT = 3'd4;

  localparam int KW_COUNT = 11;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] len;
  } tok_t;

  // keyword text, first character in the low byte, zero padded
  function automatic logic [63:0] kw_text(input int k);
    case (k)
      0:  kw_text = 64'h0000_0000_746E_696D; // mint
      1:  kw_text = 64'h0000_0000_0072_6162; // bar
      2:  kw_text = 64'h0000_0000_0000_6669; // if
      3:  kw_text = 64'h0000_0000_6669_6C65; // elif
      4:  kw_text = 64'h0000_0000_6573_6C65; // else
      5:  kw_text = 64'h0000_0000_7469_7865; // exit
      6:  kw_text = 64'h0000_0000_6575_7254; // True
      7:  kw_text = 64'h0000_0065_736C_6146; // False
      8:  kw_text = 64'h0000_0000_656E_6F4E; // None
      9:  kw_text = 64'h0000_0000_0074_6E69; // int
      default: kw_text = 64'h0000_0000_6C6F_6F62; // bool
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    case (k)
      0, 3, 4, 5, 6, 8, 10: kw_len = 4'd4;
      1, 9:                 kw_len = 4'd3;
      2:                    kw_len = 4'd2;
      default:              kw_len = 4'd5;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    case (c)
      "=", "<", ">", "+", "-", "*", "/", "%", "^", "!", "&", "|": is_oper = 1'b1;
      default: is_oper = 1'b0;
    endcase
  endfunction

  // single-byte punctuation kind, KIND_NONE if not punctuation
  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    case (c)
      ":":   punct_kind = 6'd37;
      ";":   punct_kind = 6'd38;
      "(":   punct_kind = 6'd39;
      ")":   punct_kind = 6'd40;
      "[":   punct_kind = 6'd41;
      "]":   punct_kind = 6'd42;
      "{":   punct_kind = 6'd43;
      "}":   punct_kind = 6'd44;
      8'h5C: punct_kind = 6'd45;
      default: punct_kind = KIND_NONE;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    pair_kind = KIND_NONE;
    if (c == "=") begin
      case (p)
        "=": pair_kind = 6'd13;
        "<": pair_kind = 6'd15;
        ">": pair_kind = 6'd17;
        "+": pair_kind = 6'd19;
        "-": pair_kind = 6'd22;
        "*": pair_kind = 6'd25;
        "/": pair_kind = 6'd27;
        "%": pair_kind = 6'd29;
        "^": pair_kind = 6'd31;
        "!": pair_kind = 6'd33;
        default: pair_kind = KIND_NONE;
      endcase
    end else if (p == "+" && c == "+") begin
      pair_kind = 6'd20;
    end else if (p == "-" && c == "-") begin
      pair_kind = 6'd23;
    end else if (p == "&" && c == "&") begin
      pair_kind = 6'd35;
    end else if (p == "|" && c == "|") begin
      pair_kind = 6'd36;
    end
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] p);
    case (p)
      "&": single_kind = KIND_ERROR;
      "|": single_kind = KIND_ERROR;
      "=": single_kind = 6'd14;
      "<": single_kind = 6'd16;
      ">": single_kind = 6'd18;
      "+": single_kind = 6'd21;
      "-": single_kind = 6'd24;
      "*": single_kind = 6'd26;
      "/": single_kind = 6'd28;
      "%": single_kind = 6'd30;
      "^": single_kind = 6'd32;
      default: single_kind = 6'd34;
    endcase
  endfunction

  function automatic logic [2:0] single_err(input logic [7:0] p);
    case (p)
      "&": single_err = ERR_AMP;
      "|": single_err = ERR_BAR;
      default: single_err = ERR_NONE;
    endcase
  endfunction

endpackage

[design/source_text_tokenizer.sv]
// Source text tokenizer.
// Input channel (valid/ready): action = 0 carries a source byte in ch,
// action = 1 marks end of text. Output channel (out_valid/out_ready) gives
// one token per beat: kind, start_row/start_col, length, error_code, and
// last = 1 on the final token caused by an input beat.
// Each input beat is decoded in the cycle it is accepted; its tokens (zero,
// one or two) are written into a two-entry result queue and are visible on
// the output in the following cycle. Throughput is one byte per cycle while
// the receiver takes every token; the two-entry queue is what sets it: in_ready
// drops only while the queue cannot take the worst case of the next beat, so a
// beat yielding two tokens (flush plus another, or flush plus end-of-file)
// holds off the next input beat even when the receiver takes a token every cycle.
// Receiver stall: the queue fills, in_ready drops; nothing is lost.
// Reset (rst, synchronous): row and column return to 1, scanning to idle,
// queue empties. After end-of-file the scanner returns to the reset state by
// itself so a new text may follow.
module source_text_tokenizer #(
  parameter int POS_WIDTH = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  kind,
  output logic [15:0] start_row,
  output logic [15:0] start_col,
  output logic [15:0] length,
  output logic [2:0]  error_code,
  output logic        last
);

  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
  localparam int KB = 8 * KEYWORD_CHARS;

  stt_pkg::mode_t mode, mode_next;
  logic [7:0] pend_op, pend_op_next;
  logic [KB-1:0] kw_buf, kw_buf_next;
  logic [15:0] tok_len, tok_len_next;
  logic [POS_WIDTH-1:0] tok_row, tok_col, tok_row_next, tok_col_next;
  logic [POS_WIDTH-1:0] cur_row, cur_col, cur_row_next, cur_col_next;

  // result queue: two entries, entry 0 at the head
  stt_pkg::tok_t q_tok [2];
  logic q_last [2];
  logic [1:0] q_cnt;

  stt_pkg::tok_t t0, t1;
  logic n0, n1;

  logic acc, pop;
  assign acc = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign in_ready = (q_cnt == 2'd0) || (q_cnt == 2'd1 && out_ready);

  function automatic logic [15:0] sat16(input logic [POS_WIDTH-1:0] v);
    if (POS_WIDTH > 16 && v > POS_WIDTH'(16'hFFFF)) sat16 = 16'hFFFF;
    else sat16 = 16'(v);
  endfunction

  function automatic stt_pkg::tok_t mk(input logic [5:0] k, input logic [2:0] e,
      input logic [POS_WIDTH-1:0] r, input logic [POS_WIDTH-1:0] c,
      input logic [15:0] l);
    stt_pkg::tok_t t;
    t.kind = k;
    t.err = e;
    t.row = sat16(r);
    t.col = sat16(c);
    t.len = l;
    mk = t;
  endfunction

  // keyword match against the buffered head of the identifier
  logic [5:0] word_kind;
  always_comb begin
    logic hit;
    logic [63:0] txt;
    word_kind = stt_pkg::KIND_IDENT;
    for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      txt = stt_pkg::kw_text(k);
      hit = (16'(stt_pkg::kw_len(k)) == tok_len) &&
            (int'(stt_pkg::kw_len(k)) <= KEYWORD_CHARS);
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (i < int'(stt_pkg::kw_len(k)) && kw_buf[8*i +: 8] != txt[8*i +: 8])
          hit = 1'b0;
      end
      if (hit) word_kind = 6'(k);
    end
  end

  // scanner
  always_comb begin
    logic rescan;
    logic [5:0] pk, pu;
    mode_next = mode;
    pend_op_next = pend_op;
    kw_buf_next = kw_buf;
    tok_len_next = tok_len;
    tok_row_next = tok_row;
    tok_col_next = tok_col;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    n0 = 1'b0;
    n1 = 1'b0;
    t0 = mk(stt_pkg::KIND_EOF, stt_pkg::ERR_NONE, cur_row, cur_col, 16'd0);
    t1 = t0;
    rescan = 1'b0;
    pk = stt_pkg::pair_kind(pend_op, ch);
    pu = stt_pkg::punct_kind(ch);
    if (action == 1'b0) begin
      case (mode)
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch) || ch == "_") begin
            for (int i = 1; i < KEYWORD_CHARS; i++)
              if (tok_len == 16'(i)) kw_buf_next[8*i +: 8] = ch;
            if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
          end else begin
            n0 = 1'b1;
            t0 = mk(word_kind, stt_pkg::ERR_NONE, tok_row, tok_col, tok_len);
            mode_next = stt_pkg::MODE_IDLE;
            rescan = 1'b1;
          end
        end
        stt_pkg::MODE_NUMBER: begin
          if (stt_pkg::is_digit(ch)) begin
            if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
          end else begin
            n0 = 1'b1;
            t0 = mk(stt_pkg::KIND_INTEGER, stt_pkg::ERR_NONE, tok_row, tok_col, tok_len);
            mode_next = stt_pkg::MODE_IDLE;
            rescan = 1'b1;
          end
        end
        stt_pkg::MODE_OPER: begin
          mode_next = stt_pkg::MODE_IDLE;
          n0 = 1'b1;
          if (pk != stt_pkg::KIND_NONE) begin
            t0 = mk(pk, stt_pkg::ERR_NONE, tok_row, tok_col, 16'd2);
          end else begin
            t0 = mk(stt_pkg::single_kind(pend_op), stt_pkg::single_err(pend_op),
                    tok_row, tok_col, 16'd1);
            rescan = 1'b1;
          end
        end
        stt_pkg::MODE_DOLLAR: begin
          if (ch == "$") mode_next = stt_pkg::MODE_LINE;
          else if (ch == "~") mode_next = stt_pkg::MODE_BLOCK;
          else begin
            mode_next = stt_pkg::MODE_IDLE;
            rescan = 1'b1;
          end
        end
        stt_pkg::MODE_LINE: begin
          if (ch == 8'h0A) mode_next = stt_pkg::MODE_IDLE;
        end
        stt_pkg::MODE_BLOCK: begin
          if (ch == "~") mode_next = stt_pkg::MODE_TILDE;
        end
        stt_pkg::MODE_TILDE: begin
          if (ch == "$") mode_next = stt_pkg::MODE_IDLE;
          else begin
            n0 = 1'b1;
            t0 = mk(stt_pkg::KIND_ERROR, stt_pkg::ERR_COMMENT, tok_row, tok_col, 16'd0);
            mode_next = stt_pkg::MODE_FATAL;
          end
        end
        stt_pkg::MODE_FATAL: begin
        end
        default: rescan = 1'b1;
      endcase
      // idle scan of the byte; its token lands in the slot after any flush
      if (rescan) begin
        if (stt_pkg::is_alpha(ch) || ch == "_" || stt_pkg::is_digit(ch)) begin
          mode_next = stt_pkg::is_digit(ch) ? stt_pkg::MODE_NUMBER : stt_pkg::MODE_IDENT;
          tok_row_next = cur_row;
          tok_col_next = cur_col;
          tok_len_next = 16'd1;
          kw_buf_next = KB'(ch);
        end else if (stt_pkg::is_space(ch)) begin
        end else if (ch == "$") begin
          mode_next = stt_pkg::MODE_DOLLAR;
          tok_row_next = cur_row;
          tok_col_next = cur_col;
        end else if (stt_pkg::is_oper(ch)) begin
          mode_next = stt_pkg::MODE_OPER;
          pend_op_next = ch;
          tok_row_next = cur_row;
          tok_col_next = cur_col;
        end else begin
          if (n0) n1 = 1'b1;
          else n0 = 1'b1;
          if (pu != stt_pkg::KIND_NONE) begin
            if (n1) t1 = mk(pu, stt_pkg::ERR_NONE, cur_row, cur_col, 16'd1);
            else t0 = mk(pu, stt_pkg::ERR_NONE, cur_row, cur_col, 16'd1);
          end else begin
            if (n1) t1 = mk(stt_pkg::KIND_ERROR, stt_pkg::ERR_UNKNOWN, cur_row, cur_col, 16'd1);
            else t0 = mk(stt_pkg::KIND_ERROR, stt_pkg::ERR_UNKNOWN, cur_row, cur_col, 16'd1);
          end
        end
      end
      if (ch == 8'h0A) begin
        cur_col_next = POS_ONE;
        if (cur_row != POS_MAX) cur_row_next = cur_row + POS_ONE;
      end else if (cur_col != POS_MAX) begin
        cur_col_next = cur_col + POS_ONE;
      end
    end else begin
      n0 = 1'b1;
      n1 = 1'b1;
      t1 = mk(stt_pkg::KIND_EOF, stt_pkg::ERR_NONE, cur_row, cur_col, 16'd0);
      case (mode)
        stt_pkg::MODE_IDENT:
          t0 = mk(word_kind, stt_pkg::ERR_NONE, tok_row, tok_col, tok_len);
        stt_pkg::MODE_NUMBER:
          t0 = mk(stt_pkg::KIND_INTEGER, stt_pkg::ERR_NONE, tok_row, tok_col, tok_len);
        stt_pkg::MODE_OPER:
          t0 = mk(stt_pkg::single_kind(pend_op), stt_pkg::single_err(pend_op),
                  tok_row, tok_col, 16'd1);
        stt_pkg::MODE_BLOCK, stt_pkg::MODE_TILDE:
          t0 = mk(stt_pkg::KIND_ERROR, stt_pkg::ERR_COMMENT, tok_row, tok_col, 16'd0);
        default: begin
          n1 = 1'b0;
          t0 = t1;
        end
      endcase
      mode_next = stt_pkg::MODE_IDLE;
      pend_op_next = '0;
      kw_buf_next = '0;
      tok_len_next = '0;
      tok_row_next = POS_ONE;
      tok_col_next = POS_ONE;
      cur_row_next = POS_ONE;
      cur_col_next = POS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stt_pkg::MODE_IDLE;
      pend_op <= '0;
      kw_buf <= '0;
      tok_len <= '0;
      tok_row <= POS_ONE;
      tok_col <= POS_ONE;
      cur_row <= POS_ONE;
      cur_col <= POS_ONE;
    end else if (acc) begin
      mode <= mode_next;
      pend_op <= pend_op_next;
      kw_buf <= kw_buf_next;
      tok_len <= tok_len_next;
      tok_row <= tok_row_next;
      tok_col <= tok_col_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  // queue: accept only happens when empty or draining to empty
  logic [1:0] base;
  logic [1:0] pushed;
  assign base = pop ? q_cnt - 2'd1 : q_cnt;
  assign pushed = acc ? 2'(n0) + 2'(n1) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= base + pushed;
    end
  end

  // a push always lands in an empty (or emptying) queue, so it wins over the shift
  always_ff @(posedge clk) begin
    if (acc && n0) begin
      q_tok[0] <= t0;
      q_last[0] <= !n1;
      if (n1) begin
        q_tok[1] <= t1;
        q_last[1] <= 1'b1;
      end
    end else if (pop) begin
      q_tok[0] <= q_tok[1];
      q_last[0] <= q_last[1];
    end
  end

  assign out_valid = q_cnt != 2'd0;
  assign kind = q_tok[0].kind;
  assign start_row = q_tok[0].row;
  assign start_col = q_tok[0].col;
  assign length = q_tok[0].len;
  assign error_code = q_tok[0].err;
  assign last = q_last[0];

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("queue overflow");
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    acc |-> (base == 2'd0))
    else $error("accept with queue occupied");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != stt_pkg::ERR_NONE |-> kind == stt_pkg::KIND_ERROR)
    else $error("error code on non-error token");
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == stt_pkg::KIND_EOF |-> last)
    else $error("end-of-file not last");
  a_eof_reset: assert property (@(posedge clk) disable iff (rst)
    acc && action |=> mode == stt_pkg::MODE_IDLE && cur_row == POS_ONE)
    else $error("scanner not cleared after end marker");
`endif

endmodule
